>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the barometric compensation block.
// Synthesis builds see empty bodies; simulation sees concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every rising edge outside reset.
`define BPTC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Signal must be low on the edge after a reset edge.
`define BPTC_ASSERT_RST(lbl, clk, rst_n, sig, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> !(sig)) else $error(msg);
`else
`define BPTC_ASSERT(lbl, clk, rst_n, prop, msg)
`define BPTC_ASSERT_RST(lbl, clk, rst_n, sig, msg)
`endif
`endif

>>> rtl/bptc_pkg.sv
// Package for the barometric pressure/temperature compensation block:
// field widths, shift amounts, register indexes and inter-module structs.
// No dependencies.
package bptc_pkg;

  localparam int RAW_W   = 24;
  localparam int CAL_W   = 16;
  localparam int TEMP_W  = 19;
  localparam int PRES_W  = 32;
  localparam int IN_W    = 2 * RAW_W;
  localparam int OUT_W   = 56;
  localparam int CFG_A_W = 3;

  localparam int TEMP_SHIFT = 23;
  localparam int OFF_SHIFT  = 7;
  localparam int SENS_SHIFT = 8;
  localparam int SQ_SHIFT   = 31;
  localparam int P_SHIFT1   = 21;
  localparam int P_SHIFT2   = 15;

  // first-order datapath
  localparam int DT_W    = RAW_W + 2;
  localparam int PROD_W  = DT_W + CAL_W + 1;
  localparam int SQ_W    = 2 * DT_W;
  localparam int T2_W    = 18;
  localparam int OFF1_W  = PROD_W - OFF_SHIFT;
  localparam int SENS1_W = 36;

  // second-order datapath
  localparam int DIF_W  = TEMP_W + 1;
  localparam int SQT_W  = 36;
  localparam int CORR_W = SQT_W + 4;
  localparam int OFF_W  = 40;
  localparam int SENS_W = 40;

  // pressure datapath, SENS split as hi * 2^21 + lo
  localparam int SLO_W = P_SHIFT1;
  localparam int SHI_W = SENS_W - SLO_W;
  localparam int HI_PW = RAW_W + 1 + SHI_W;
  localparam int LO_PW = RAW_W + SLO_W;
  localparam int ACC_W = HI_PW + 1;
  localparam int Q_W   = 48;

  localparam logic signed [TEMP_W-1:0] TEMP_REF  = 19'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_COLD = -19'sd1500;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_C1 = 3'd0,
    CFG_C2 = 3'd1,
    CFG_C3 = 3'd2,
    CFG_C4 = 3'd3,
    CFG_C5 = 3'd4,
    CFG_C6 = 3'd5
  } cfg_addr_t;

  typedef struct packed {
    logic [CAL_W-1:0] c1;
    logic [CAL_W-1:0] c2;
    logic [CAL_W-1:0] c3;
    logic [CAL_W-1:0] c4;
    logic [CAL_W-1:0] c5;
    logic [CAL_W-1:0] c6;
  } cal_t;

  typedef struct packed {
    logic [RAW_W-1:0]          d1;
    logic signed [TEMP_W-1:0]  temp1;
    logic [T2_W-1:0]           t2;
    logic signed [OFF1_W-1:0]  off1;
    logic signed [SENS1_W-1:0] sens1;
  } first_t;

  typedef struct packed {
    logic [RAW_W-1:0]         d1;
    logic signed [TEMP_W-1:0] temp;
    logic signed [OFF_W-1:0]  off;
    logic signed [SENS_W-1:0] sens;
  } second_t;

endpackage

>>> rtl/bptc_cfg.sv
// Calibration word registers written through the plain write port.
// Depends on bptc_pkg.
module bptc_cfg
  import bptc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CAL_W-1:0]   cfg_wdata,
  output cal_t               cal
);

  cal_t cal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_C1:  cal_r.c1 <= cfg_wdata;
        CFG_C2:  cal_r.c2 <= cfg_wdata;
        CFG_C3:  cal_r.c3 <= cfg_wdata;
        CFG_C4:  cal_r.c4 <= cfg_wdata;
        CFG_C5:  cal_r.c5 <= cfg_wdata;
        CFG_C6:  cal_r.c6 <= cfg_wdata;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  assign cal = cal_r;

endmodule

>>> rtl/bptc_first.sv
// First-order stages: dT, the four dT products, then TEMP, OFF, SENS and T2.
// Three register stages with bubble-collapsing valids. Depends on bptc_pkg.
module bptc_first
  import bptc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cal_t             cal,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic [RAW_W-1:0] raw_pressure,
  input  logic [RAW_W-1:0] raw_temperature,
  output logic             down_valid,
  input  logic             down_ready,
  output first_t           down_data
);

  logic [2:0] v_r;
  logic [3:0] en;

  assign en[3] = down_ready;
  assign en[2] = !v_r[2] || en[3];
  assign en[1] = !v_r[1] || en[2];
  assign en[0] = !v_r[0] || en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  // stage A
  logic signed [DT_W-1:0] dt_nxt, dt_r;
  logic [RAW_W-1:0]       d1_a_r;

  assign dt_nxt = $signed({2'b00, raw_temperature}) - $signed({2'b00, cal.c5, 8'h00});

  // stage B
  logic signed [PROD_W-1:0] prod_t_nxt, prod_off_nxt, prod_sens_nxt;
  logic signed [PROD_W-1:0] prod_t_r, prod_off_r, prod_sens_r;
  logic signed [SQ_W-1:0]   sq_nxt, sq_r;
  logic [RAW_W-1:0]         d1_b_r;

  assign prod_t_nxt    = dt_r * $signed({1'b0, cal.c6});
  assign prod_off_nxt  = dt_r * $signed({1'b0, cal.c4});
  assign prod_sens_nxt = dt_r * $signed({1'b0, cal.c3});
  assign sq_nxt        = dt_r * dt_r;

  // stage C
  first_t down_nxt, down_r;

  always_comb begin
    down_nxt.d1    = d1_b_r;
    down_nxt.temp1 = TEMP_REF + $signed(prod_t_r[TEMP_SHIFT+TEMP_W-1:TEMP_SHIFT]);
    down_nxt.t2    = sq_r[SQ_SHIFT+T2_W-1:SQ_SHIFT];
    down_nxt.off1  = $signed({4'b0000, cal.c2, 16'h0000})
                   + $signed(prod_off_r[PROD_W-1:OFF_SHIFT]);
    down_nxt.sens1 = $signed({5'b00000, cal.c1, 15'h0000})
                   + $signed({prod_sens_r[PROD_W-1], prod_sens_r[PROD_W-1:SENS_SHIFT]});
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dt_r   <= dt_nxt;
      d1_a_r <= raw_pressure;
    end
    if (en[1]) begin
      prod_t_r    <= prod_t_nxt;
      prod_off_r  <= prod_off_nxt;
      prod_sens_r <= prod_sens_nxt;
      sq_r        <= sq_nxt;
      d1_b_r      <= d1_a_r;
    end
    if (en[2]) begin
      down_r <= down_nxt;
    end
  end

  assign up_ready   = en[0];
  assign down_valid = v_r[2];
  assign down_data  = down_r;

endmodule

>>> rtl/bptc_second.sv
// Second-order correction stages: squares of the temperature offsets, the
// OFF2/SENS2 terms, then the corrected OFF and SENS. Depends on bptc_pkg.
module bptc_second
  import bptc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    up_valid,
  output logic    up_ready,
  input  first_t  up_data,
  output logic    down_valid,
  input  logic    down_ready,
  output second_t down_data
);

  logic [2:0] v_r;
  logic [3:0] en;

  assign en[3] = down_ready;
  assign en[2] = !v_r[2] || en[3];
  assign en[1] = !v_r[1] || en[2];
  assign en[0] = !v_r[0] || en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  // stage A: range flags, squares, corrected temperature
  logic                       low_nxt, cold_nxt;
  logic signed [DIF_W-1:0]    da, db, temp2_full;
  logic signed [2*DIF_W-1:0]  f_nxt, g_nxt;
  logic signed [TEMP_W-1:0]   temp_nxt;

  assign low_nxt    = up_data.temp1 < TEMP_REF;
  assign cold_nxt   = up_data.temp1 < TEMP_COLD;
  assign da         = DIF_W'(up_data.temp1) - DIF_W'(TEMP_REF);
  assign db         = DIF_W'(up_data.temp1) - DIF_W'(TEMP_COLD);
  assign f_nxt      = da * da;
  assign g_nxt      = db * db;
  assign temp2_full = DIF_W'(up_data.temp1)
                    - $signed({{(DIF_W-T2_W){1'b0}}, up_data.t2});
  assign temp_nxt   = low_nxt ? temp2_full[TEMP_W-1:0] : up_data.temp1;

  logic                      low_a_r, cold_a_r;
  logic [SQT_W-1:0]          f_r, g_r;
  logic signed [TEMP_W-1:0]  temp_a_r;
  logic signed [OFF1_W-1:0]  off1_a_r;
  logic signed [SENS1_W-1:0] sens1_a_r;
  logic [RAW_W-1:0]          d1_a_r;

  // stage B: 5f/2 + 7g and 5f/4 + 11g/2, zero at or above 20.00 C
  logic [CORR_W-1:0] f5, g7, g11, off2_nxt, sens2_nxt;

  always_comb begin
    f5  = {4'b0000, f_r} + {2'b00, f_r, 2'b00};
    g7  = {1'b0, g_r, 3'b000} - {4'b0000, g_r};
    g11 = {1'b0, g_r, 3'b000} + {3'b000, g_r, 1'b0} + {4'b0000, g_r};
    off2_nxt  = '0;
    sens2_nxt = '0;
    if (low_a_r) begin
      off2_nxt  = (f5 >> 1) + (cold_a_r ? g7 : '0);
      sens2_nxt = (f5 >> 2) + (cold_a_r ? (g11 >> 1) : '0);
    end
  end

  logic [CORR_W-1:0]         off2_r, sens2_r;
  logic signed [TEMP_W-1:0]  temp_b_r;
  logic signed [OFF1_W-1:0]  off1_b_r;
  logic signed [SENS1_W-1:0] sens1_b_r;
  logic [RAW_W-1:0]          d1_b_r;

  // stage C
  second_t down_nxt, down_r;

  always_comb begin
    down_nxt.d1   = d1_b_r;
    down_nxt.temp = temp_b_r;
    down_nxt.off  = OFF_W'(off1_b_r) - $signed(off2_r);
    down_nxt.sens = SENS_W'(sens1_b_r) - $signed(sens2_r);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      low_a_r   <= low_nxt;
      cold_a_r  <= cold_nxt;
      f_r       <= f_nxt[SQT_W-1:0];
      g_r       <= g_nxt[SQT_W-1:0];
      temp_a_r  <= temp_nxt;
      off1_a_r  <= up_data.off1;
      sens1_a_r <= up_data.sens1;
      d1_a_r    <= up_data.d1;
    end
    if (en[1]) begin
      off2_r    <= off2_nxt;
      sens2_r   <= sens2_nxt;
      temp_b_r  <= temp_a_r;
      off1_b_r  <= off1_a_r;
      sens1_b_r <= sens1_a_r;
      d1_b_r    <= d1_a_r;
    end
    if (en[2]) begin
      down_r <= down_nxt;
    end
  end

  assign up_ready   = en[0];
  assign down_valid = v_r[2];
  assign down_data  = down_r;

endmodule

>>> rtl/bptc_press.sv
// Pressure stages: D1*SENS as two partial products, the >>21 sum, then
// (... - OFF) >>15 into the output register. Depends on bptc_pkg, assert_macros.svh.
`include "assert_macros.svh"
module bptc_press
  import bptc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     up_valid,
  output logic                     up_ready,
  input  second_t                  up_data,
  output logic                     down_valid,
  input  logic                     down_ready,
  output logic signed [TEMP_W-1:0] temperature,
  output logic signed [PRES_W-1:0] pressure
);

  logic [2:0] v_r;
  logic [3:0] en;

  assign en[3] = down_ready;
  assign en[2] = !v_r[2] || en[3];
  assign en[1] = !v_r[1] || en[2];
  assign en[0] = !v_r[0] || en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  // stage A: SENS = hi * 2^21 + lo, lo unsigned
  logic signed [HI_PW-1:0] pm_hi_nxt, pm_hi_r;
  logic [LO_PW-1:0]        pm_lo_nxt, pm_lo_r;
  logic signed [OFF_W-1:0] off_a_r, off_b_r;
  logic signed [TEMP_W-1:0] temp_a_r, temp_b_r;

  assign pm_hi_nxt = $signed({1'b0, up_data.d1}) * $signed(up_data.sens[SENS_W-1:SLO_W]);
  assign pm_lo_nxt = up_data.d1 * up_data.sens[SLO_W-1:0];

  // stage B: floor(D1*SENS / 2^21) exactly
  logic signed [ACC_W-1:0] acc_nxt, acc_r;

  assign acc_nxt = ACC_W'(pm_hi_r)
                 + $signed({{(ACC_W-(LO_PW-SLO_W)){1'b0}}, pm_lo_r[LO_PW-1:SLO_W]});

  // stage C
  logic signed [Q_W-1:0]    q;
  logic signed [PRES_W-1:0] pres_nxt, pres_r;
  logic signed [TEMP_W-1:0] temp_r;

  assign q        = Q_W'(acc_r) - Q_W'(off_b_r);
  assign pres_nxt = q[P_SHIFT2+PRES_W-1:P_SHIFT2];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pm_hi_r  <= pm_hi_nxt;
      pm_lo_r  <= pm_lo_nxt;
      off_a_r  <= up_data.off;
      temp_a_r <= up_data.temp;
    end
    if (en[1]) begin
      acc_r    <= acc_nxt;
      off_b_r  <= off_a_r;
      temp_b_r <= temp_a_r;
    end
    if (en[2]) begin
      pres_r <= pres_nxt;
      temp_r <= temp_b_r;
    end
  end

  assign up_ready    = en[0];
  assign down_valid  = v_r[2];
  assign temperature = temp_r;
  assign pressure    = pres_r;

  `BPTC_ASSERT_RST(a_rst_empty, clk, rst_n, |v_r, "pipeline valid set after reset")
  `BPTC_ASSERT(a_hold_result, clk, rst_n, v_r[2] && !down_ready |=> v_r[2], "result dropped")
  `BPTC_ASSERT(a_empty_ready, clk, rst_n, !v_r[0] |-> up_ready, "empty stage refuses data")

endmodule

>>> rtl/baro_pressure_temp_compensation.sv
// Barometric pressure and temperature compensation, second-order, top level.
// Depends on bptc_pkg, bptc_cfg, bptc_first, bptc_second, bptc_press.
//
// Usage:
//   Write the six 16-bit calibration words through cfg_we/cfg_addr/cfg_wdata
//   (index 0..5, one write per cycle, only while no transaction is in
//   flight). Writes to indexes 6 and 7 are ignored.
//   Each in_ transaction carries raw pressure and raw temperature counts; each
//   produces exactly one out_ transaction with the compensated temperature
//   (0.01 C, 19-bit two's complement) and pressure (Pa, low 32 bits).
// Pipeline: nine register stages (dT, products, first order, squares,
//   corrections, OFF/SENS, partial products, shift-add, output register).
// Throughput: one transaction per cycle while out_tready is high.
// Reset: synchronous rst_n clears all valid bits and the calibration words.
// Stall: while out_tready is low the result holds and bubbles inside the
//   pipeline collapse; in_tready falls only once every stage is occupied.
module baro_pressure_temp_compensation
  import bptc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [IN_W-1:0]    in_tdata,   // raw_pressure[23:0], raw_temperature[47:24]
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_W-1:0]   out_tdata,  // temperature[18:0], pressure[50:19], zero pad
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CAL_W-1:0]   cfg_wdata
);

  cal_t    cal;
  first_t  first_data;
  second_t second_data;
  logic    first_valid, first_ready, second_valid, second_ready;
  logic signed [TEMP_W-1:0] temperature;
  logic signed [PRES_W-1:0] pressure;

  bptc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cal       (cal)
  );

  bptc_first u_first (
    .clk             (clk),
    .rst_n           (rst_n),
    .cal             (cal),
    .up_valid        (in_tvalid),
    .up_ready        (in_tready),
    .raw_pressure    (in_tdata[RAW_W-1:0]),
    .raw_temperature (in_tdata[IN_W-1:RAW_W]),
    .down_valid      (first_valid),
    .down_ready      (first_ready),
    .down_data       (first_data)
  );

  bptc_second u_second (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (first_valid),
    .up_ready   (first_ready),
    .up_data    (first_data),
    .down_valid (second_valid),
    .down_ready (second_ready),
    .down_data  (second_data)
  );

  bptc_press u_press (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (second_valid),
    .up_ready    (second_ready),
    .up_data     (second_data),
    .down_valid  (out_tvalid),
    .down_ready  (out_tready),
    .temperature (temperature),
    .pressure    (pressure)
  );

  assign out_tdata = {{(OUT_W-TEMP_W-PRES_W){1'b0}}, pressure, temperature};

endmodule

>>> test/baro_pressure_temp_compensation_tb.sv
// Self-checking testbench for baro_pressure_temp_compensation.
// Needs bptc_pkg and the block RTL. Results are compared against a
// second-order compensation predictor kept inside this file.
module baro_pressure_temp_compensation_tb;
  import bptc_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int PHASES = 10;
  localparam int PHASE_SAMPLES = 155;
  localparam logic [CFG_A_W-1:0] CFG_SPARE6 = 3'd6;
  localparam logic [CFG_A_W-1:0] CFG_SPARE7 = 3'd7;
  localparam longint WARM_LIMIT = 2000;
  localparam longint COLD_LIMIT = -1500;
  localparam logic [RAW_W-1:0] RAW_MAX = 24'hFFFFFF;
  localparam logic [CAL_W-1:0] CAL_MAX = 16'hFFFF;

  typedef struct {
    logic signed [TEMP_W-1:0] temp;
    logic signed [PRES_W-1:0] pres;
  } reading_t;

  typedef enum logic {ROW_CAL, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [CFG_A_W-1:0] addr;
    logic [CAL_W-1:0] word;
    logic [RAW_W-1:0] d1;
    logic [RAW_W-1:0] d2;
    bit               typed;
    reading_t         want;
  } stim_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;   // raw_pressure[23:0], raw_temperature[47:24]
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;      // temperature[18:0], pressure[50:19], zero pad
  logic cfg_we = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr = '0;
  logic [CAL_W-1:0] cfg_wdata = '0;

  cal_t cal_copy = '0;
  reading_t pending_readings [$];
  stim_row_t stim_tab [$];
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int rx_mode_left = 0;

  baro_pressure_temp_compensation uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Second-order compensation; every shift of a signed term floors.
  function automatic reading_t compensate(input logic [RAW_W-1:0] d1_raw,
                                          input logic [RAW_W-1:0] d2_raw,
                                          input cal_t cw);
    longint d1, d2, dt, temp, off, sens, t2, f, g, off2, sens2, p;
    reading_t r;
    d1 = d1_raw;
    d2 = d2_raw;
    dt = d2 - (longint'(cw.c5) << 8);
    temp = WARM_LIMIT + ((dt * longint'(cw.c6)) >>> 23);
    off = (longint'(cw.c2) << 16) + ((longint'(cw.c4) * dt) >>> 7);
    sens = (longint'(cw.c1) << 15) + ((longint'(cw.c3) * dt) >>> 8);
    if (temp < WARM_LIMIT) begin
      t2 = (dt * dt) >>> 31;
      f = (temp - WARM_LIMIT) * (temp - WARM_LIMIT);
      off2 = (5 * f) >>> 1;
      sens2 = (5 * f) >>> 2;
      if (temp < COLD_LIMIT) begin
        g = (temp - COLD_LIMIT) * (temp - COLD_LIMIT);
        off2 = off2 + 7 * g;
        sens2 = sens2 + ((11 * g) >>> 1);
      end
      temp = temp - t2;
      off = off - off2;
      sens = sens - sens2;
    end
    p = (((d1 * sens) >>> 21) - off) >>> 15;
    r.temp = temp[TEMP_W-1:0];
    r.pres = p[PRES_W-1:0];
    return r;
  endfunction

  function automatic void add_cal(input logic [CFG_A_W-1:0] addr, input logic [CAL_W-1:0] word);
    stim_row_t row;
    row = '{kind: ROW_CAL, addr: addr, word: word, d1: '0, d2: '0, typed: 1'b0,
            want: '{temp: '0, pres: '0}};
    stim_tab.push_back(row);
  endfunction

  function automatic void add_sample(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2,
                                     input bit typed, input int t_exp, input int p_exp);
    stim_row_t row;
    row = '{kind: ROW_SAMPLE, addr: '0, word: '0, d1: d1, d2: d2, typed: typed,
            want: '{temp: t_exp[TEMP_W-1:0], pres: p_exp[PRES_W-1:0]}};
    stim_tab.push_back(row);
  endfunction

  // Holds cfg_we high; the caller lowers it after the last write of a batch.
  task automatic write_cal(input logic [CFG_A_W-1:0] addr, input logic [CAL_W-1:0] word);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= word;
    case (addr)
      CFG_C1: cal_copy.c1 = word;
      CFG_C2: cal_copy.c2 = word;
      CFG_C3: cal_copy.c3 = word;
      CFG_C4: cal_copy.c4 = word;
      CFG_C5: cal_copy.c5 = word;
      CFG_C6: cal_copy.c6 = word;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_readings.size() != 0);
  endtask

  task automatic send_sample(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2,
                             input reading_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {d2, d1};
    do @(posedge clk); while (!in_tready);
    pending_readings.push_back(want);
    burst_left--;
  endtask

  function automatic logic [CAL_W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CAL_MAX;
      default: return CAL_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw_temp(input cal_t cw);
    int center, v;
    center = int'(cw.c5) << 8;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return RAW_W'($urandom());
      4, 5, 6: v = center + $urandom_range(0, 1 << 21) - (1 << 20);
      7: return '0;
      8: return RAW_MAX;
      default: v = center + $urandom_range(0, 600) - 300;
    endcase
    if (v < 0) v = 0;
    if (v > int'(RAW_MAX)) v = int'(RAW_MAX);
    return v[RAW_W-1:0];
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw_press();
    case ($urandom_range(0, 9))
      8: return '0;
      9: return RAW_MAX;
      default: return RAW_W'($urandom());
    endcase
  endfunction

  // Receiver: ready pattern switches at random between open, coin-flip, sparse and periodic modes.
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_mode_left <= $urandom_range(20, 300);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      RX_OPEN:     out_tready <= 1'b1;
      RX_COIN:     out_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE:   out_tready <= ($urandom_range(0, 3) == 0);
      RX_PERIODIC: out_tready <= (rx_mode_left[2:0] == 3'd0);
    endcase
  end

  always @(posedge clk) begin : check_results
    reading_t want;
    logic signed [TEMP_W-1:0] got_temp;
    logic signed [PRES_W-1:0] got_pres;
    if (rst_n && out_tvalid && out_tready) begin
      got_temp = out_tdata[TEMP_W-1:0];
      got_pres = out_tdata[TEMP_W +: PRES_W];
      if (pending_readings.size() == 0) begin
        $error("result transaction with nothing expected: temperature %0d, pressure %0d",
               got_temp, got_pres);
        mismatch_count++;
      end else begin
        want = pending_readings.pop_front();
        if (got_temp !== want.temp) begin
          $error("temperature: expected %0d, got %0d", want.temp, got_temp);
          mismatch_count++;
        end
        if (got_pres !== want.pres) begin
          $error("pressure: expected %0d, got %0d", want.pres, got_pres);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    bit cal_open;
    cal_t cw;
    logic [RAW_W-1:0] d1, d2;

    // zero calibration: temperature sits at 20.00 C and pressure at zero
    add_sample(24'h000000, 24'h000000, 1'b1, 2000, 0);
    add_sample(RAW_MAX, RAW_MAX, 1'b1, 2000, 0);
    add_sample(24'h555555, 24'hAAAAAA, 1'b1, 2000, 0);
    // typical factory words
    add_cal(CFG_C1, 16'd40127);
    add_cal(CFG_C2, 16'd36924);
    add_cal(CFG_C3, 16'd23317);
    add_cal(CFG_C4, 16'd23282);
    add_cal(CFG_C5, 16'd33464);
    add_cal(CFG_C6, 16'd28312);
    add_cal(CFG_SPARE6, CAL_MAX);   // unused index, must not land anywhere
    add_cal(CFG_SPARE7, 16'h1234);
    add_sample(24'd9085466, 24'd8569150, 1'b0, 0, 0);
    add_sample(24'd0, 24'd8566784, 1'b0, 0, 0);       // dT = 0, exactly 20.00 C
    add_sample(RAW_MAX, 24'd8566783, 1'b0, 0, 0);     // just below 20.00 C
    add_sample(24'd8000000, 24'd7529764, 1'b0, 0, 0); // -15.00 C, no extra term
    add_sample(24'd8000000, 24'd7529763, 1'b0, 0, 0); // just below -15.00 C
    add_sample(RAW_MAX, 24'd0, 1'b0, 0, 0);
    add_sample(RAW_MAX, RAW_MAX, 1'b0, 0, 0);
    add_sample(24'd0, 24'd0, 1'b0, 0, 0);
    // all words at maximum: deepest cold correction
    add_cal(CFG_C1, CAL_MAX);
    add_cal(CFG_C2, CAL_MAX);
    add_cal(CFG_C3, CAL_MAX);
    add_cal(CFG_C4, CAL_MAX);
    add_cal(CFG_C5, CAL_MAX);
    add_cal(CFG_C6, CAL_MAX);
    add_sample(RAW_MAX, 24'd0, 1'b0, 0, 0);
    add_sample(RAW_MAX, RAW_MAX, 1'b0, 0, 0);
    add_sample(24'd0, 24'hFFFF00, 1'b0, 0, 0);
    add_sample(24'h123456, 24'h7FFFFF, 1'b0, 0, 0);
    add_cal(CFG_C1, 16'h0000);
    add_cal(CFG_C3, 16'h0000);
    add_cal(CFG_C5, 16'h0000);
    add_sample(RAW_MAX, RAW_MAX, 1'b0, 0, 0);
    add_sample(24'd0, RAW_MAX, 1'b0, 0, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    cal_open = 1'b0;
    foreach (stim_tab[i]) begin
      if (stim_tab[i].kind == ROW_CAL) begin
        if (!cal_open) settle();
        write_cal(stim_tab[i].addr, stim_tab[i].word);
        cal_open = 1'b1;
      end else begin
        if (cal_open) cfg_we <= 1'b0;
        cal_open = 1'b0;
        send_sample(stim_tab[i].d1, stim_tab[i].d2,
                    stim_tab[i].typed ? stim_tab[i].want
                                      : compensate(stim_tab[i].d1, stim_tab[i].d2, cal_copy));
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph == 0) begin
        cw = '{default: CAL_MAX};
      end else if (ph == 1) begin
        cw = '{c1: CAL_MAX, c2: '0, c3: CAL_MAX, c4: '0, c5: 16'd32768, c6: CAL_MAX};
      end else begin
        cw = '{c1: pick_word(), c2: pick_word(), c3: pick_word(),
               c4: pick_word(), c5: pick_word(), c6: pick_word()};
      end
      write_cal(CFG_C1, cw.c1);
      write_cal(CFG_C2, cw.c2);
      write_cal(CFG_C3, cw.c3);
      write_cal(CFG_C4, cw.c4);
      write_cal(CFG_C5, cw.c5);
      write_cal(CFG_C6, cw.c6);
      if ($urandom_range(0, 1))
        write_cal($urandom_range(0, 1) ? CFG_SPARE6 : CFG_SPARE7, CAL_W'($urandom()));
      cfg_we <= 1'b0;
      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        if (ph == 3 && n == PHASE_SAMPLES / 2) settle();
        d1 = pick_raw_press();
        d2 = pick_raw_temp(cal_copy);
        send_sample(d1, d2, compensate(d1, d2, cal_copy));
      end
    end

    settle();
    repeat (12) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/bptc_pkg.sv
rtl/bptc_cfg.sv
rtl/bptc_first.sv
rtl/bptc_second.sv
rtl/bptc_press.sv
rtl/baro_pressure_temp_compensation.sv
test/baro_pressure_temp_compensation_tb.sv
